### rtl/sta_pkg.sv
// Package: types and constants shared by the station table modules.
package sta_pkg;

    localparam int unsigned DEFAULT_DEPTH = 64;
    localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

    localparam logic [1:0] FUNC_OBSERVE = 2'd0;
    localparam logic [1:0] FUNC_AGE     = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    localparam logic [2:0] ST_UPDATED = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_AGED    = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    typedef struct packed {
        logic [1:0]        func;
        logic [47:0]       station_mac;
        logic [47:0]       access_point_bssid;
        logic              bssid_present;
        logic signed [7:0] signal_dbm;
        logic [31:0]       now_ms;
        logic [5:0]        read_slot;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        slot_index;
        logic [6:0]        aged_count;
        logic [47:0]       entry_mac;
        logic [47:0]       entry_bssid;
        logic signed [7:0] entry_signal;
        logic [1:0]        entry_flags;
        logic [31:0]       entry_seen_ms;
        logic [6:0]        used_entries;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_WAIT,
        S_CHECK,
        S_WRITE,
        S_READ,
        S_RDATA,
        S_OUT
    } eng_state_t;

endpackage

### rtl/sta_front.sv
// Front: accepts items, drops unknown codes, holds a two-entry queue.
module sta_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sta_pkg::in_item_t in_item,
    output logic            q_valid,
    input  logic            q_take,
    output sta_pkg::in_item_t q_item
);
    sta_pkg::in_item_t buf_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    // unknown function codes are swallowed here
    assign push = in_valid && !in_stall && (in_item.func != sta_pkg::FUNC_NONE);
    assign pop = q_take && q_valid;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = buf_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### rtl/sta_engine.sv
// Back end: walks the table to carry out observe and age items; reads one slot for read items.
module sta_engine #(
    parameter int unsigned DEPTH = sta_pkg::DEFAULT_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       timeout,
    input  logic              q_valid,
    output logic              q_take,
    input  sta_pkg::in_item_t q_item,
    output logic              out_valid,
    input  logic              out_stall,
    output sta_pkg::out_item_t out_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef struct packed {
        logic [47:0] mac;
        logic [47:0] bssid;
        logic [7:0]  sig;
        logic [31:0] seen;
    } entry_t;

    entry_t mem [DEPTH];
    entry_t rd_reg;
    logic [DEPTH-1:0] active_reg, linked_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] reuse_reg, reuse_next;
    logic          reuse_ok_reg, reuse_ok_next;
    logic          hit_reg, hit_next;
    logic [6:0]    aged_reg, aged_next;
    sta_pkg::in_item_t cur_reg;
    sta_pkg::out_item_t res_reg, res_next;
    logic          res_valid_reg;
    sta_pkg::eng_state_t state_reg, state_next;

    logic [AW-1:0] ia;
    logic          mem_we;
    entry_t        wdata;
    logic [AW-1:0] waddr;
    logic          in_range;
    logic [31:0]   elapsed;

    assign ia = idx_reg[AW-1:0];
    assign in_range = idx_reg < fill_reg;
    assign elapsed = cur_reg.now_ms - rd_reg.seen;
    assign out_valid = res_valid_reg;
    assign out_item = res_reg;
    // a new item starts only once the result register is free or being freed
    assign q_take = (state_reg == sta_pkg::S_IDLE) && q_valid
                    && (!res_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sta_pkg::S_IDLE:  if (q_take) state_next = (q_item.func == sta_pkg::FUNC_READ)
                                  ? sta_pkg::S_READ : sta_pkg::S_WALK;
            sta_pkg::S_WALK:  state_next = in_range ? sta_pkg::S_WAIT : sta_pkg::S_WRITE;
            sta_pkg::S_WAIT:  state_next = sta_pkg::S_CHECK;
            sta_pkg::S_CHECK:
            begin
                if (cur_reg.func == sta_pkg::FUNC_OBSERVE && rd_reg.mac == cur_reg.station_mac)
                    state_next = sta_pkg::S_WRITE;
                else
                    state_next = sta_pkg::S_WALK;
            end
            sta_pkg::S_WRITE: state_next = sta_pkg::S_OUT;
            sta_pkg::S_READ:  state_next = sta_pkg::S_RDATA;
            sta_pkg::S_RDATA: state_next = sta_pkg::S_OUT;
            sta_pkg::S_OUT:   state_next = sta_pkg::S_IDLE;
            default:          state_next = sta_pkg::S_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        idx_next = idx_reg;
        reuse_next = reuse_reg;
        reuse_ok_next = reuse_ok_reg;
        hit_next = hit_reg;
        aged_next = aged_reg;
        fill_next = fill_reg;
        res_next = res_reg;
        mem_we = 1'b0;
        waddr = ia;
        wdata = '0;
        case (state_reg)
            sta_pkg::S_IDLE:
            begin
                idx_next = (q_item.func == sta_pkg::FUNC_READ)
                    ? CW'(q_item.read_slot) : '0;
                reuse_ok_next = 1'b0;
                hit_next = 1'b0;
                aged_next = '0;
            end
            sta_pkg::S_CHECK:
            begin
                if (cur_reg.func == sta_pkg::FUNC_OBSERVE)
                begin
                    if (rd_reg.mac == cur_reg.station_mac)
                        hit_next = 1'b1;
                    else
                    begin
                        if (!reuse_ok_reg && !active_reg[ia])
                        begin
                            reuse_ok_next = 1'b1;
                            reuse_next = idx_reg;
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (elapsed > timeout && active_reg[ia])
                        aged_next = aged_reg + 7'd1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            sta_pkg::S_WRITE:
            begin
                res_next = '0;
                if (cur_reg.func == sta_pkg::FUNC_AGE)
                begin
                    res_next.status = sta_pkg::ST_AGED;
                    res_next.aged_count = aged_reg;
                end
                else
                begin
                    wdata.mac = cur_reg.station_mac;
                    wdata.sig = cur_reg.signal_dbm;
                    wdata.seen = cur_reg.now_ms;
                    wdata.bssid = cur_reg.bssid_present ? cur_reg.access_point_bssid : 48'd0;
                    if (hit_reg)
                    begin
                        if (!cur_reg.bssid_present) wdata.bssid = rd_reg.bssid;
                        mem_we = 1'b1;
                        waddr = ia;
                        res_next.status = sta_pkg::ST_UPDATED;
                        res_next.slot_index = 6'(idx_reg);
                    end
                    else if (reuse_ok_reg)
                    begin
                        mem_we = 1'b1;
                        waddr = reuse_reg[AW-1:0];
                        res_next.status = sta_pkg::ST_INSERTED;
                        res_next.slot_index = 6'(reuse_reg);
                    end
                    else if (fill_reg < DEPTH_C)
                    begin
                        mem_we = 1'b1;
                        waddr = fill_reg[AW-1:0];
                        fill_next = fill_reg + 1'b1;
                        res_next.status = sta_pkg::ST_INSERTED;
                        res_next.slot_index = 6'(fill_reg);
                    end
                    else
                        res_next.status = sta_pkg::ST_DROPPED;
                end
                res_next.used_entries = 7'(fill_next);
            end
            sta_pkg::S_RDATA:
            begin
                res_next = '0;
                res_next.status = sta_pkg::ST_READ;
                res_next.slot_index = cur_reg.read_slot;
                if (in_range)
                begin
                    res_next.entry_mac = rd_reg.mac;
                    res_next.entry_bssid = rd_reg.bssid;
                    res_next.entry_signal = rd_reg.sig;
                    res_next.entry_flags = {linked_reg[ia], active_reg[ia]};
                    res_next.entry_seen_ms = rd_reg.seen;
                end
                res_next.used_entries = 7'(fill_reg);
            end
            default: ;
        endcase
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[waddr] <= wdata;
        rd_reg <= mem[ia];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_take) cur_reg <= q_item;
        idx_reg <= idx_next;
        reuse_reg <= reuse_next;
        res_reg <= res_next;
        aged_reg <= aged_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sta_pkg::S_IDLE;
            fill_reg <= '0;
            active_reg <= '0;
            linked_reg <= '0;
            reuse_ok_reg <= 1'b0;
            hit_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            reuse_ok_reg <= reuse_ok_next;
            hit_reg <= hit_next;
            if (state_reg == sta_pkg::S_OUT)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !out_stall)
                res_valid_reg <= 1'b0;
            if (state_reg == sta_pkg::S_CHECK && cur_reg.func == sta_pkg::FUNC_AGE
                && elapsed > timeout)
                active_reg[ia] <= 1'b0;
            if (mem_we)
            begin
                active_reg[waddr] <= 1'b1;
                if (cur_reg.bssid_present) linked_reg[waddr] <= 1'b1;
                else if (!hit_reg) linked_reg[waddr] <= 1'b0;
            end
        end
    end
endmodule

### rtl/station_table_with_aging_core.sv
// Top level: station table with aging, front queue plus walking back end.
// Observe and age items walk the used entries through the WALK, WAIT and CHECK states
// for each entry (a match ends an observe walk early); reads go through the READ and
// RDATA states, and the OUT state then marks the result valid.
// One item in the back end at a time; it starts only when the previous result has
// been taken, so a stalled result holds back the walk. The front queue holds two more.
// Reset clears valid flags, fill count and queues; entry contents are kept; timeout 60000 ms.
module station_table_with_aging_core #(
    parameter int unsigned TABLE_DEPTH = sta_pkg::DEFAULT_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  sta_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output sta_pkg::out_item_t out_item
);
    logic [31:0] timeout_reg;
    logic q_valid, q_take;
    sta_pkg::in_item_t q_item;

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) timeout_reg <= sta_pkg::TIMEOUT_RESET;
        else if (cfg_we) timeout_reg <= cfg_wdata;
    end

    sta_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    sta_engine #(.DEPTH(TABLE_DEPTH)) u_engine (
        .clk(clk), .rst_n(rst_n), .timeout(timeout_reg),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );
endmodule
